[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for concurrent assertions on a clock with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

[hw/rtl/ordenc_pkg.sv]
// ----------------------------------------------------------------------------
// ordenc_pkg
// Types, constants and Roman numeral tables of the ordinal numeral encoder.
// ----------------------------------------------------------------------------
package ordenc_pkg;

    localparam int unsigned ALPHA_SLOTS = 4;      // digits of a 16-bit value in base 26
    localparam int unsigned DENOMS      = 13;
    localparam logic [3:0]  DENOM_TOP   = 4'd12;  // index of 1000

    localparam logic [15:0] ROMAN_LIMIT = 16'd5000;
    // floor(x / 26) == (x * 40330) >> 20 for every x below 2**16.
    localparam logic [15:0] RECIP_26    = 16'd40330;
    localparam int unsigned RECIP_SHIFT = 20;

    localparam logic [6:0] CHAR_A     = 7'h41;
    localparam logic [6:0] CHAR_QMARK = 7'h3F;
    localparam logic [6:0] CHAR_NONE  = 7'h00;
    localparam logic [6:0] CASE_BIT   = 7'h20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADIV,
        ST_AOUT,
        ST_ROMAN,
        ST_SPECIAL
    } t_state;

    typedef struct packed {
        logic load;
        logic alpha_step;
        logic alpha_emit;
        logic roman_skip;
        logic roman_emit;
        logic special_emit;
    } t_cmd;

    typedef struct packed {
        logic in_zero;
        logic in_big;
        logic rem_zero;
        logic ndig_one;
        logic rem_ge;
        logic roman_fin;
        logic out_free;
    } t_stat;

    function automatic logic [15:0] denom_value(input logic [3:0] idx);
        logic [15:0] v;
        case (idx)
            4'd0:    v = 16'd1;
            4'd1:    v = 16'd4;
            4'd2:    v = 16'd5;
            4'd3:    v = 16'd9;
            4'd4:    v = 16'd10;
            4'd5:    v = 16'd40;
            4'd6:    v = 16'd50;
            4'd7:    v = 16'd90;
            4'd8:    v = 16'd100;
            4'd9:    v = 16'd400;
            4'd10:   v = 16'd500;
            4'd11:   v = 16'd900;
            4'd12:   v = 16'd1000;
            default: v = 16'd1;
        endcase
        return v;
    endfunction

    // Upper-case first symbol of each denomination.
    function automatic logic [6:0] denom_first(input logic [3:0] idx);
        logic [6:0] c;
        case (idx)
            4'd0, 4'd1, 4'd3:  c = 7'h49; // I
            4'd2:              c = 7'h56; // V
            4'd4, 4'd5, 4'd7:  c = 7'h58; // X
            4'd6:              c = 7'h4C; // L
            4'd8, 4'd9, 4'd11: c = 7'h43; // C
            4'd10:             c = 7'h44; // D
            4'd12:             c = 7'h4D; // M
            default:           c = 7'h49;
        endcase
        return c;
    endfunction

    // Upper-case second symbol of a subtractive pair, zero for single symbols.
    function automatic logic [6:0] denom_second(input logic [3:0] idx);
        logic [6:0] c;
        case (idx)
            4'd1:    c = 7'h56; // V
            4'd3:    c = 7'h58; // X
            4'd5:    c = 7'h4C; // L
            4'd7:    c = 7'h43; // C
            4'd9:    c = 7'h44; // D
            4'd11:   c = 7'h4D; // M
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/ordenc_ctrl.sv]
// ----------------------------------------------------------------------------
// ordenc_ctrl
// Sequencer that walks the datapath through one value at a time.
// ----------------------------------------------------------------------------
module ordenc_ctrl
    import ordenc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_alpha,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_stat.in_zero) begin
                        n_state = ST_SPECIAL;
                    end else if (i_in_alpha) begin
                        n_state = ST_ADIV;
                    end else if (i_stat.in_big) begin
                        n_state = ST_SPECIAL;
                    end else begin
                        n_state = ST_ROMAN;
                    end
                end
            end
            ST_ADIV: begin
                if (i_stat.rem_zero) begin
                    n_state = ST_AOUT;
                end
            end
            ST_AOUT: begin
                if (i_stat.out_free && i_stat.ndig_one) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ROMAN: begin
                if (i_stat.rem_ge && i_stat.out_free && i_stat.roman_fin) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SPECIAL: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:    o_cmd.load         = accept;
            ST_ADIV:    o_cmd.alpha_step   = !i_stat.rem_zero;
            ST_AOUT:    o_cmd.alpha_emit   = i_stat.out_free;
            ST_ROMAN: begin
                o_cmd.roman_emit = i_stat.rem_ge && i_stat.out_free;
                o_cmd.roman_skip = !i_stat.rem_ge;
            end
            ST_SPECIAL: o_cmd.special_emit = i_stat.out_free;
            default:    o_cmd = '0;
        endcase
    end

endmodule

[hw/rtl/ordenc_dp.sv]
// ----------------------------------------------------------------------------
// ordenc_dp
// Value register, base-26 digit store, Roman denomination walker and the
// output item register.
// ----------------------------------------------------------------------------
module ordenc_dp
    import ordenc_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_count_value,
    input  logic        i_upper,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [6:0]  o_char_code,
    output logic        o_is_empty,
    output logic        o_last
);

    // The input field carries 16 bits, so no more than that is ever used.
    localparam int unsigned VW = (VALUE_BITS < 16) ? VALUE_BITS : 16;

    logic [VW-1:0] r_rem;
    logic          r_upper;
    logic [4:0]    r_digits [ALPHA_SLOTS];
    logic [2:0]    r_ndig;
    logic [3:0]    r_didx;
    logic          r_pair;
    logic          r_out_valid;
    logic [6:0]    r_out_char;
    logic          r_out_empty;
    logic          r_out_last;

    logic [VW-1:0]    value_in;
    logic [VW-1:0]    rem_m1;
    logic [VW+15:0]   prod;
    logic [VW-1:0]    quot;
    logic [VW+4:0]    quot26;
    logic [4:0]       digit;
    logic [2:0]       ndig_m1;
    logic [6:0]       case_or;
    logic [15:0]      rem_ext;
    logic [15:0]      dval;
    logic             is_pair;
    logic             first_half;
    logic [6:0]       roman_char;
    logic             out_free;

    assign value_in = i_count_value[VW-1:0];
    assign out_free = !r_out_valid || i_out_ready;
    assign case_or  = r_upper ? 7'h00 : CASE_BIT;

    // Base-26 digit extraction on (remaining - 1) by reciprocal multiply.
    assign rem_m1 = r_rem - VW'(1);
    assign prod   = rem_m1 * RECIP_26;
    assign quot   = VW'(prod >> RECIP_SHIFT);
    assign quot26 = ({5'd0, quot} << 4) + ({5'd0, quot} << 3) + ({5'd0, quot} << 1);
    assign digit  = 5'(rem_m1 - quot26[VW-1:0]);
    assign ndig_m1 = r_ndig - 3'd1;

    assign rem_ext    = 16'(r_rem);
    assign dval       = denom_value(r_didx);
    assign is_pair    = (denom_second(r_didx) != 7'h00);
    assign first_half = is_pair && !r_pair;
    assign roman_char = (first_half || !is_pair) ? denom_first(r_didx)
                                                 : denom_second(r_didx);

    always_comb begin
        o_stat           = '0;
        o_stat.in_zero   = (value_in == '0);
        o_stat.in_big    = (16'(value_in) >= ROMAN_LIMIT);
        o_stat.rem_zero  = (r_rem == '0);
        o_stat.ndig_one  = (r_ndig == 3'd1);
        o_stat.rem_ge    = (rem_ext >= dval);
        o_stat.roman_fin = !first_half && (rem_ext == dval);
        o_stat.out_free  = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem   <= value_in;
            r_upper <= i_upper;
            r_ndig  <= 3'd0;
            r_didx  <= DENOM_TOP;
            r_pair  <= 1'b0;
        end
        if (i_cmd.alpha_step) begin
            r_rem                <= quot;
            r_digits[r_ndig[1:0]] <= digit;
            r_ndig               <= r_ndig + 3'd1;
        end
        if (i_cmd.alpha_emit) begin
            r_ndig <= ndig_m1;
        end
        if (i_cmd.roman_skip) begin
            r_didx <= r_didx - 4'd1;
        end
        if (i_cmd.roman_emit) begin
            if (first_half) begin
                r_pair <= 1'b1;
            end else begin
                r_pair <= 1'b0;
                r_rem  <= VW'(rem_ext - dval);
            end
        end
    end

    // Output item register; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.alpha_emit) begin
            r_out_char  <= (CHAR_A + 7'(r_digits[ndig_m1[1:0]])) | case_or;
            r_out_empty <= 1'b0;
            r_out_last  <= (r_ndig == 3'd1);
        end else if (i_cmd.roman_emit) begin
            r_out_char  <= roman_char | case_or;
            r_out_empty <= 1'b0;
            r_out_last  <= !first_half && (rem_ext == dval);
        end else if (i_cmd.special_emit) begin
            r_out_char  <= (r_rem == '0) ? CHAR_NONE : CHAR_QMARK;
            r_out_empty <= (r_rem == '0);
            r_out_last  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.alpha_emit || i_cmd.roman_emit || i_cmd.special_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_char_code = r_out_char;
    assign o_is_empty  = r_out_empty;
    assign o_last      = r_out_last;

endmodule

[hw/rtl/ordinal_numeral_encoder_core.sv]
// ----------------------------------------------------------------------------
// ordinal_numeral_encoder_core
// Renders an unsigned count as list-ordinal ASCII text, alpha or Roman.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: tdata holds the count, tuser the style (0 lower alpha,
//   1 upper alpha, 2 lower Roman, 3 upper Roman). Each accepted item yields a
//   run of output items, one character each, most significant first, with
//   tlast on the final character of the run.
//   A count of zero yields one item with a character code of zero and the
//   empty flag in tuser set. A Roman count of 5000 or more yields a single '?'.
//   Timing: one value is handled at a time. Alpha loads the value, takes one
//   base-26 digit per divider step (at most 4) until the remainder is zero,
//   then emits the characters. Roman loads the value, then walks the
//   denominations down, skipping each one above the remainder (at most 12)
//   and emitting the characters (at most 16). Each character appears on the
//   output in the cycle after it is formed. The one-digit-per-cycle divider
//   and the single-step denomination walker carry out these steps.
//   tready is high only while the sequencer is idle; the last character of
//   a run may still sit in the output register when the next item is taken.
//   If the receiver stalls, the current character holds in the output
//   register and the sequencer waits. Synchronous reset empties the output
//   register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module ordinal_numeral_encoder_core
    import ordenc_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] count_value
    input  logic [1:0]  i_s_tuser,   // [1:0] style
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [6:0] char_code, [7] zero fill
    output logic        o_m_tuser,   // [0] is_empty
    output logic        o_m_tlast
);

    t_cmd       cmd;
    t_stat      stat;
    logic [6:0] char_code;

    // The sequencer picks alpha or Roman from the high style bit; the low
    // bit selects the letter case in the datapath.
    ordenc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_alpha (!i_s_tuser[1]),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ordenc_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_count_value (i_s_tdata),
        .i_upper       (i_s_tuser[0]),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_char_code   (char_code),
        .o_is_empty    (o_m_tuser),
        .o_last        (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, char_code};

endmodule

[hw/rtl/ordenc_chk.sv]
// ----------------------------------------------------------------------------
// ordenc_chk
// Port-level checks on the ordinal numeral encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ordenc_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       i_s_tready,
    input logic [7:0] i_m_tdata,
    input logic       i_m_tvalid,
    input logic       i_m_tready,
    input logic       i_m_tuser,
    input logic       i_m_tlast
);

    // A stalled output item must not change.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser) && $stable(i_m_tlast))

    // An empty item stands alone and carries no character.
    `ASSERT_IMPLIES(a_empty_form, i_clk, i_rst_n, i_m_tvalid && i_m_tuser, i_m_tlast && (i_m_tdata == 8'd0))

    // Every real character is a 7-bit ASCII code above the space.
    `ASSERT_IMPLIES(a_char_nonzero, i_clk, i_rst_n, i_m_tvalid && !i_m_tuser, (i_m_tdata[7] == 1'b0) && (i_m_tdata[6:0] > 7'h20))

    // Only one value is in work at a time.
    `ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_s_tvalid && i_s_tready, !i_s_tready)

endmodule

bind ordinal_numeral_encoder_core ordenc_chk u_ordenc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);

[tb/sv/ordinal_numeral_encoder_core_tb.sv]
// ----------------------------------------------------------------------------
// ordinal_numeral_encoder_core_tb
// Self-checking bench for the list-ordinal encoder. A directed set of counts
// (zero, alpha digit roll-overs, the longest Roman numerals, the Roman range
// limit and the largest count) is followed by constrained-random counts in all
// four styles. Every accepted count is rendered by an independent model into
// the characters expected on the output stream. Both stream sides idle at
// random, and there is one long receiver hold-off and one drain pause.
// ----------------------------------------------------------------------------
module ordinal_numeral_encoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ordenc_pkg::*;

    typedef enum logic [1:0] {
        STYLE_LOWER_ALPHA,
        STYLE_UPPER_ALPHA,
        STYLE_LOWER_ROMAN,
        STYLE_UPPER_ROMAN
    } t_numeral_style;

    // One output character as the block should present it.
    typedef struct packed {
        logic [6:0] code;
        logic       empty;
        logic       last;
    } t_glyph;

    localparam int unsigned ALPHA_RADIX    = 26;
    localparam int unsigned ROMAN_STEPS    = 13;
    localparam int unsigned RANDOM_COUNTS  = 346;
    localparam int unsigned DRAIN_CYCLES   = 40;
    localparam int unsigned HOLD_OFF_LEN   = 300;
    localparam int unsigned WATCHDOG_LIMIT = 3000;

    // Roman denominations from the largest down, with their upper-case symbols.
    // A tail of zero marks a denomination written with a single symbol.
    localparam int unsigned ROMAN_WEIGHT [ROMAN_STEPS] =
        '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
    localparam byte ROMAN_HEAD [ROMAN_STEPS] =
        '{"M", "C", "D", "C", "C", "X", "L", "X", "X", "I", "V", "I", "I"};
    localparam byte ROMAN_TAIL [ROMAN_STEPS] =
        '{8'h00, "M", 8'h00, "D", 8'h00, "C", 8'h00, "L", 8'h00, "X", 8'h00, "V", 8'h00};

    // ------------------------------------------------------------------------
    // Scoreboard: renders each accepted count into the characters it must
    // produce and checks the output stream against them in order.
    // ------------------------------------------------------------------------
    class ordinal_scoreboard;
        t_glyph      pending_glyphs[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // Render a count in the given style and queue its characters.
        function void note_count(input logic [15:0] count, input t_numeral_style style);
            t_glyph      g;
            logic [6:0]  case_off;
            int unsigned rest;
            int unsigned ndig;
            int unsigned digit [8];
            int          i;

            case_off = (style == STYLE_UPPER_ALPHA || style == STYLE_UPPER_ROMAN)
                       ? 7'h00 : CASE_BIT;
            g.empty = 1'b0;
            g.last  = 1'b0;

            if (count == 16'd0) begin
                // A zero count renders nothing and is flagged as empty.
                g.code  = CHAR_NONE;
                g.empty = 1'b1;
                g.last  = 1'b1;
                pending_glyphs.push_back(g);
                return;
            end

            if (style == STYLE_LOWER_ALPHA || style == STYLE_UPPER_ALPHA) begin
                // Bijective base 26: take one off before each digit, so that
                // 26 is a single z and 27 rolls over to aa.
                rest = count;
                ndig = 0;
                while (rest > 0) begin
                    rest--;
                    digit[ndig] = rest % ALPHA_RADIX;
                    rest = rest / ALPHA_RADIX;
                    ndig++;
                end
                for (i = int'(ndig) - 1; i >= 0; i--) begin
                    g.code = CHAR_A + 7'(digit[i]) + case_off;
                    pending_glyphs.push_back(g);
                end
            end else if (count >= ROMAN_LIMIT) begin
                g.code = CHAR_QMARK;
                pending_glyphs.push_back(g);
            end else begin
                // Greedy subtractive numerals, M repeated up to four times.
                rest = count;
                for (i = 0; i < ROMAN_STEPS; i++) begin
                    while (rest >= ROMAN_WEIGHT[i]) begin
                        g.code = ROMAN_HEAD[i][6:0] + case_off;
                        pending_glyphs.push_back(g);
                        if (ROMAN_TAIL[i] != 8'h00) begin
                            g.code = ROMAN_TAIL[i][6:0] + case_off;
                            pending_glyphs.push_back(g);
                        end
                        rest = rest - ROMAN_WEIGHT[i];
                    end
                end
            end
            pending_glyphs[pending_glyphs.size() - 1].last = 1'b1;
        endfunction

        // Compare one accepted output item with the oldest expected character.
        task check_glyph(input logic [7:0] data, input logic empty_flag,
                         input logic last_flag);
            t_glyph want;
            if (pending_glyphs.size() == 0) begin
                report_mismatch($sformatf("character 0x%02h with nothing pending", data));
                return;
            end
            want = pending_glyphs.pop_front();
            if (data[6:0] !== want.code)
                report_mismatch($sformatf("char_code 0x%02h, wanted 0x%02h",
                                          data[6:0], want.code));
            if (data[7] !== 1'b0)
                report_mismatch("tdata fill bit is not zero");
            if (empty_flag !== want.empty)
                report_mismatch($sformatf("is_empty %b, wanted %b", empty_flag, want.empty));
            if (last_flag !== want.last)
                report_mismatch($sformatf("tlast %b, wanted %b on char 0x%02h",
                                          last_flag, want.last, want.code));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test and its stimulus signals.
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // [15:0] count_value
    logic [1:0]  i_s_tuser;   // [1:0] style
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // [6:0] char_code, [7] zero fill
    logic        o_m_tuser;   // [0] is_empty
    logic        o_m_tlast;

    ordinal_numeral_encoder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    ordinal_scoreboard sb = new();

    // Shared between the sender and the receiver: calm switches random idling
    // off on both sides, hold_request asks the receiver for a long hold-off.
    bit          calm;
    bit          hold_request;
    int unsigned hold_left;
    int unsigned quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------

    // Offer one count from a falling edge and return at the falling edge after
    // it has been taken. Random idle cycles go in front of the item.
    task automatic send_count(input logic [15:0] count, input t_numeral_style style);
        while (!calm && $urandom_range(0, 99) < 37) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 16'($urandom);
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= count;
        i_s_tuser  <= style;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        sb.note_count(count, style);
        @(negedge i_clk);
    endtask

    // Random counts lean towards the Roman range and short alpha runs, with
    // full-width values, the oversized Roman range and the odd zero mixed in.
    function automatic logic [15:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return 16'd0;
        else if (roll < 30)
            return 16'($urandom_range(1, 60));
        else if (roll < 60)
            return 16'($urandom_range(1, 4999));
        else if (roll < 75)
            return 16'($urandom_range(5000, 65535));
        return 16'($urandom);
    endfunction

    initial begin
        logic [15:0] alpha_counts [8] = '{1, 26, 27, 702, 703, 18278, 18279, 65535};
        logic [15:0] roman_counts [12] =
            '{1, 4, 9, 14, 49, 400, 1994, 3888, 4888, 4999, 5000, 65535};
        int i;

        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = 16'd0;
        i_s_tuser    = STYLE_LOWER_ALPHA;
        calm         = 1'b0;
        hold_request = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: zero in every style, the alpha digit roll-overs up to
        // four letters, and the Roman extremes including the sixteen-character
        // numeral, the last valid value and the first oversized one.
        for (i = 0; i < 4; i++)
            send_count(16'd0, t_numeral_style'(i));
        for (i = 0; i < 8; i++)
            send_count(alpha_counts[i], i[0] ? STYLE_UPPER_ALPHA : STYLE_LOWER_ALPHA);
        for (i = 0; i < 12; i++)
            send_count(roman_counts[i], i[0] ? STYLE_UPPER_ROMAN : STYLE_LOWER_ROMAN);

        // Random part.
        for (i = 0; i < RANDOM_COUNTS; i++) begin
            calm = (i >= 180 && i < 260);
            if (i == 300) begin
                // Let the block drain completely before carrying on.
                i_s_tvalid <= 1'b0;
                while (sb.pending_glyphs.size() != 0)
                    @(negedge i_clk);
                repeat (DRAIN_CYCLES) @(negedge i_clk);
            end
            send_count(pick_count(), t_numeral_style'($urandom_range(0, 3)));
            // Ask for the receiver hold-off while items keep being offered.
            if (i == 100)
                hold_request = 1'b1;
        end
        calm = 1'b0;
        i_s_tvalid <= 1'b0;

        while (sb.pending_glyphs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.pending_glyphs.size() != 0)
            sb.report_mismatch("characters still expected at the end of the run");
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver side: random back-pressure, plus one long hold-off on request
    // so that the output register and then the input side stall.
    // ------------------------------------------------------------------------
    initial begin
        i_m_tready = 1'b0;
        hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_LEN;
                i_m_tready   <= 1'b0;
            end else begin
                i_m_tready <= calm || ($urandom_range(0, 99) >= 37);
            end
        end
    end

    // Every item taken from the block is checked at the edge that moves it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_glyph(o_m_tdata, o_m_tuser, o_m_tlast);
    end

    // The watchdog ends the run when neither side has moved an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

[ordinal_numeral_encoder_core.f]
+incdir+hw/rtl
hw/rtl/ordenc_pkg.sv
hw/rtl/ordenc_ctrl.sv
hw/rtl/ordenc_dp.sv
hw/rtl/ordinal_numeral_encoder_core.sv
hw/rtl/ordenc_chk.sv
tb/sv/ordinal_numeral_encoder_core_tb.sv
